// ----- design/rifd_pkg.sv -----
package rifd_pkg;

  // Operand layout codes
  typedef enum logic [3:0] {
    F_NONE = 4'd0,
    F_D    = 4'd1,
    F_R    = 4'd2,
    F_RR   = 4'd3,
    F_RRR  = 4'd4,
    F_RPR  = 4'd5,
    F_RM   = 4'd6,
    F_RRD  = 4'd7,
    F_RD   = 4'd8,
    F_RH   = 4'd9,
    F_RRH  = 4'd10,
    F_W    = 4'd11,
    F_RMDP = 4'd12,
    F_RMPD = 4'd13,
    F_MP   = 4'd14,
    F_RMP  = 4'd15
  } op_form_e;

  // Operand handling classes for the minor opcodes of major 0
  typedef enum logic [4:0] {
    MC_INV,
    MC_NONE,
    MC_NONE_COND,
    MC_D15,
    MC_D5_COND,
    MC_D5,
    MC_R_COND,
    MC_RM,
    MC_RRR,
    MC_RR_TEST,
    MC_RR_DA,
    MC_RR_DA_COND,
    MC_RR_AB_CU,
    MC_RR_AB,
    MC_RRD,
    MC_CEL,
    MC_RPR,
    MC_MP,
    MC_RMP
  } minor_cls_e;

  // One decode record
  typedef struct packed {
    logic [2:0] used;
    logic [6:0] mn;
    op_form_e   form;
    logic [3:0] cond;
    logic [1:0] test;
    logic       suf;
    logic [4:0] rd;
    logic [4:0] ra;
    logic [4:0] rb;
    logic [31:0] val;
  } dec_rec_t;

  // Field widths
  localparam int unsigned HalfW  = 16;
  localparam int unsigned WordW  = 30;
  localparam int unsigned AvailW = 3;
  localparam int unsigned AddrW  = 32;

  // Byte counts
  localparam logic [2:0] USED_NONE  = 3'd0;
  localparam logic [2:0] USED_SHORT = 3'd2;
  localparam logic [2:0] USED_LONG  = 3'd4;

  // Defaults of an undecoded record
  localparam logic [3:0] COND_ALWAYS = 4'd15;
  localparam logic [1:0] TEST_NONE   = 2'd3;

  // Major opcodes
  localparam logic [4:0] MAJ_MINOR     = 5'h00;
  localparam logic [4:0] MAJ_IMM       = 5'h01;
  localparam logic [4:0] MAJ_JUMP      = 5'h02;
  localparam logic [4:0] MAJ_LDST_PRE  = 5'h03;
  localparam logic [4:0] MAJ_BRANCH    = 5'h04;
  localparam logic [4:0] MAJ_IMM_SH    = 5'h05;
  localparam logic [4:0] MAJ_LDST_POST = 5'h07;
  localparam logic [4:0] MAJ_RI        = 5'h08;
  localparam logic [4:0] MAJ_RI_C      = 5'h0C;
  localparam logic [4:0] MAJ_RI_D      = 5'h0D;

  // Mnemonic numbers that are bases of groups
  localparam logic [6:0] MN_MFCEL = 7'd34;
  localparam logic [6:0] MN_MTCEL = 7'd37;
  localparam logic [6:0] MN_ADDI  = 7'd61;
  localparam logic [6:0] MN_J     = 7'd66;
  localparam logic [6:0] MN_LW    = 7'd67;
  localparam logic [6:0] MN_B     = 7'd75;
  localparam logic [6:0] MN_ADDIS = 7'd76;
  localparam logic [6:0] MN_ADDRI = 7'd81;

  // Coprocessor move selectors in the rB field
  localparam logic [4:0] CEL_LO   = 5'd1;
  localparam logic [4:0] CEL_HI   = 5'd2;
  localparam logic [4:0] CEL_BOTH = 5'd3;

  // Mnemonic per minor opcode of major 0 (0: invalid or computed apart)
  localparam logic [6:0] MINOR_MN [64] = '{
    7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,
    7'd9,  7'd10, 7'd11, 7'd0,  7'd12, 7'd13, 7'd0,  7'd14,
    7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22,
    7'd23, 7'd0,  7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
    7'd30, 7'd31, 7'd32, 7'd33, 7'd0,  7'd0,  7'd0,  7'd0,
    7'd40, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47,
    7'd48, 7'd49, 7'd0,  7'd50, 7'd51, 7'd52, 7'd0,  7'd53,
    7'd54, 7'd0,  7'd55, 7'd56, 7'd57, 7'd58, 7'd59, 7'd60
  };

  // Operand class per minor opcode of major 0
  localparam minor_cls_e MINOR_CLS [64] = '{
    MC_NONE,     MC_D15,      MC_D5_COND,  MC_D5,
    MC_R_COND,   MC_NONE,     MC_RM,       MC_RM,
    MC_RRR,      MC_RRR,      MC_RRR,      MC_INV,
    MC_RR_TEST,  MC_RR_TEST,  MC_INV,      MC_RR_DA,
    MC_RRR,      MC_RRR,      MC_RRR,      MC_RRR,
    MC_RRD,      MC_RRD,      MC_RRD,      MC_RRD,
    MC_RRR,      MC_INV,      MC_RRR,      MC_RRR,
    MC_RRR,      MC_RRR,      MC_RRR,      MC_RRR,
    MC_RR_AB_CU, MC_RR_AB,    MC_RR_AB,    MC_RR_AB,
    MC_CEL,      MC_CEL,      MC_INV,      MC_INV,
    MC_RPR,      MC_RPR,      MC_NONE_COND, MC_RR_DA_COND,
    MC_RR_DA,    MC_RR_DA,    MC_RR_DA,    MC_RR_DA,
    MC_MP,       MC_RMP,      MC_INV,      MC_RMP,
    MC_RMP,      MC_RMP,      MC_INV,      MC_MP,
    MC_RRD,      MC_INV,      MC_RRD,      MC_RRD,
    MC_RRD,      MC_RRD,      MC_RRD,      MC_RRD
  };

  // Immediate sub-opcode (word bits 19:17) to mnemonic offset
  localparam logic [2:0] IMM_SUB_K [8] = '{
    3'd0, 3'd0, 3'd1, 3'd0, 3'd2, 3'd3, 3'd4, 3'd0
  };
  // Bit set where the sub-opcode is defined
  localparam logic [7:0] IMM_SUB_VLD = 8'b0111_0101;

  // Record of an undecoded item
  localparam dec_rec_t REC_EMPTY = '{
    used: USED_NONE, mn: 7'd0, form: F_NONE, cond: COND_ALWAYS,
    test: TEST_NONE, suf: 1'b0, rd: 5'd0, ra: 5'd0, rb: 5'd0, val: 32'd0
  };

endpackage

// ----- design/rifd_minor_dec.sv -----
module rifd_minor_dec
  import rifd_pkg::*;
(
  input  logic [WordW-1:0] word_i,
  output dec_rec_t         rec_o
);

  logic       cu;
  logic [4:0] rd_f;
  logic [4:0] ra_f;
  logic [4:0] rb_f;
  logic [5:0] minor;
  logic [6:0] cel_base;

  assign cu       = word_i[0];
  assign rd_f     = word_i[24:20];
  assign ra_f     = word_i[19:15];
  assign rb_f     = word_i[14:10];
  assign minor    = word_i[6:1];
  assign cel_base = minor[0] ? MN_MTCEL : MN_MFCEL;

  // Operand extraction per minor class
  always_comb begin
    rec_o    = REC_EMPTY;
    rec_o.mn = MINOR_MN[minor];
    case (MINOR_CLS[minor])
      MC_NONE: begin
        rec_o.form = F_NONE;
      end
      MC_NONE_COND: begin
        rec_o.form = F_NONE;
        rec_o.cond = rb_f[3:0];
      end
      MC_D15: begin
        rec_o.form = F_D;
        rec_o.val  = {17'd0, word_i[24:10]};
      end
      MC_D5_COND: begin
        rec_o.form = F_D;
        rec_o.val  = {27'd0, ra_f};
        rec_o.cond = rb_f[3:0];
      end
      MC_D5: begin
        rec_o.form = F_D;
        rec_o.val  = {27'd0, ra_f};
      end
      MC_R_COND: begin
        rec_o.form = F_R;
        rec_o.rd   = ra_f;
        rec_o.cond = rb_f[3:0];
        rec_o.suf  = cu;
      end
      MC_RM: begin
        rec_o.form = F_RM;
        rec_o.rd   = rd_f;
        rec_o.ra   = ra_f;
      end
      MC_RRR: begin
        rec_o.form = F_RRR;
        rec_o.rd   = rd_f;
        rec_o.ra   = ra_f;
        rec_o.rb   = rb_f;
        rec_o.suf  = cu;
      end
      MC_RR_TEST: begin
        rec_o.form = F_RR;
        rec_o.rd   = ra_f;
        rec_o.ra   = rb_f;
        rec_o.test = rd_f[1:0];
        rec_o.suf  = cu;
      end
      MC_RR_DA: begin
        rec_o.form = F_RR;
        rec_o.rd   = rd_f;
        rec_o.ra   = ra_f;
        rec_o.suf  = cu;
      end
      MC_RR_DA_COND: begin
        rec_o.form = F_RR;
        rec_o.rd   = rd_f;
        rec_o.ra   = ra_f;
        rec_o.cond = rb_f[3:0];
      end
      MC_RR_AB_CU: begin
        rec_o.form = F_RR;
        rec_o.rd   = ra_f;
        rec_o.ra   = rb_f;
        rec_o.suf  = cu;
      end
      MC_RR_AB: begin
        rec_o.form = F_RR;
        rec_o.rd   = ra_f;
        rec_o.ra   = rb_f;
      end
      MC_RRD: begin
        rec_o.form = F_RRD;
        rec_o.rd   = rd_f;
        rec_o.ra   = ra_f;
        rec_o.rb   = rb_f;
        rec_o.suf  = cu;
      end
      MC_CEL: begin
        // rB selects lo, hi or both; anything else stays invalid
        if (rb_f == CEL_LO || rb_f == CEL_HI) begin
          rec_o.mn   = cel_base + {2'd0, rb_f} - 7'd1;
          rec_o.form = F_R;
          rec_o.rd   = rd_f;
        end else if (rb_f == CEL_BOTH) begin
          rec_o.mn   = cel_base + 7'd2;
          rec_o.form = F_RR;
          rec_o.rd   = rd_f;
          rec_o.ra   = ra_f;
        end else begin
          rec_o.mn = 7'd0;
        end
      end
      MC_RPR: begin
        rec_o.form = F_RPR;
        rec_o.rd   = ra_f;
        rec_o.ra   = rb_f;
      end
      MC_MP: begin
        rec_o.form = F_MP;
        rec_o.ra   = ra_f;
      end
      MC_RMP: begin
        rec_o.form = F_RMP;
        rec_o.rd   = rd_f;
        rec_o.ra   = ra_f;
      end
      default: begin
        rec_o.mn = 7'd0;
      end
    endcase
  end

endmodule

// ----- design/rifd_major_dec.sv -----
module rifd_major_dec
  import rifd_pkg::*;
(
  input  logic [HalfW-1:0]  first_half_i,
  input  logic [HalfW-1:0]  second_half_i,
  input  logic [AvailW-1:0] bytes_available_i,
  input  logic [AddrW-1:0]  current_pc_i,
  output dec_rec_t          rec_o
);

  logic [WordW-1:0] word;
  logic [4:0]       major;
  logic [4:0]       rd_f;
  logic [4:0]       ra_f;
  logic [2:0]       sub;
  logic [6:0]       imm_base;
  logic [31:0]      br_disp;
  logic [6:0]       ri_off;
  dec_rec_t         minor_rec;

  // 30-bit word: low 15 bits of each halfword, first one low
  assign word     = {second_half_i[14:0], first_half_i[14:0]};
  assign major    = word[29:25];
  assign rd_f     = word[24:20];
  assign ra_f     = word[19:15];
  assign sub      = word[19:17];
  assign imm_base = (major == MAJ_IMM) ? MN_ADDI : MN_ADDIS;
  assign br_disp  = {{12{word[24]}}, word[24:15], word[9:1], 1'b0};
  assign ri_off   = (major == MAJ_RI_C) ? 7'd1 : ((major == MAJ_RI_D) ? 7'd2 : 7'd0);

  rifd_minor_dec u_minor (
    .word_i (word),
    .rec_o  (minor_rec)
  );

  // Length check, then decode of the major opcode
  always_comb begin
    rec_o = REC_EMPTY;
    if (bytes_available_i >= AvailW'(2)) begin
      if (!first_half_i[15]) begin
        rec_o.used = USED_SHORT;
      end else if (bytes_available_i >= AvailW'(4)) begin
        case (major)
          MAJ_MINOR: begin
            rec_o = minor_rec;
          end
          MAJ_IMM, MAJ_IMM_SH: begin
            if (IMM_SUB_VLD[sub]) begin
              rec_o.mn  = imm_base + {4'd0, IMM_SUB_K[sub]};
              rec_o.rd  = rd_f;
              rec_o.suf = word[0];
              if (IMM_SUB_K[sub] < 3'd2) begin
                rec_o.form = F_RD;
                rec_o.val  = {{16{word[16]}}, word[16:1]};
              end else begin
                rec_o.form = F_RH;
                rec_o.val  = {16'd0, word[16:1]};
              end
            end
          end
          MAJ_JUMP: begin
            rec_o.mn   = MN_J;
            rec_o.form = F_W;
            rec_o.val  = {current_pc_i[31:26], 1'b0, word[24:1], 1'b0};
            rec_o.suf  = word[0];
          end
          MAJ_LDST_PRE, MAJ_LDST_POST: begin
            rec_o.mn   = MN_LW + {4'd0, word[2:0]};
            rec_o.form = (major == MAJ_LDST_PRE) ? F_RMDP : F_RMPD;
            rec_o.rd   = rd_f;
            rec_o.ra   = ra_f;
            rec_o.val  = {{20{word[14]}}, word[14:3]};
          end
          MAJ_BRANCH: begin
            rec_o.mn   = MN_B;
            rec_o.form = F_W;
            rec_o.val  = current_pc_i + br_disp;
            rec_o.cond = word[13:10];
            rec_o.suf  = word[0];
          end
          MAJ_RI, MAJ_RI_C, MAJ_RI_D: begin
            rec_o.mn   = MN_ADDRI + ri_off;
            rec_o.form = F_RRH;
            rec_o.rd   = ra_f;
            rec_o.ra   = rd_f;
            rec_o.val  = {{18{word[14]}}, word[14:1]};
            rec_o.suf  = word[0];
          end
          default: begin
            rec_o = REC_EMPTY;
          end
        endcase
        rec_o.used = USED_LONG;
      end
    end
  end

endmodule

// ----- design/risc_instruction_field_decoder_core.sv -----
// An accepted input transaction goes through the input register, the decode
// logic and the result register before its result is offered on the output.
// Throughput: one transaction per cycle while the output is not stalled, set
// by the single decode pass between the two registers; a stalled output
// still lets one more item in.
// Reset clears both valid flags; data registers are not reset.
module risc_instruction_field_decoder_core
  import rifd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] first_half, [31:16] second_half, [34:32] bytes_available,
  // [66:35] current_pc, [71:67] zero
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] consumed_bytes, [9:3] mnemonic, [13:10] operand_form,
  // [17:14] cond_code, [19:18] test_mode, [20] suffix_flag, [25:21] reg_d,
  // [30:26] reg_a, [35:31] reg_b, [67:36] operand_value, [71:68] zero
  output logic [71:0] m_axis_tdata_o
);

  logic              in_vld_q, in_vld_d;
  logic [HalfW-1:0]  first_q;
  logic [HalfW-1:0]  second_q;
  logic [AvailW-1:0] avail_q;
  logic [AddrW-1:0]  pc_q;
  logic              out_vld_q, out_vld_d;
  dec_rec_t          out_q;
  dec_rec_t          dec_rec;
  logic              s_fire;
  logic              m_fire;
  logic              adv_out;

  // Handshake
  assign adv_out         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv_out;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire          = out_vld_q && m_axis_tready_i;

  // Valid flags
  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (adv_out) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv_out) begin
      out_vld_d = 1'b1;
    end else if (m_fire) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      first_q  <= s_axis_tdata_i[15:0];
      second_q <= s_axis_tdata_i[31:16];
      avail_q  <= s_axis_tdata_i[34:32];
      pc_q     <= s_axis_tdata_i[66:35];
    end
  end

  rifd_major_dec u_dec (
    .first_half_i      (first_q),
    .second_half_i     (second_q),
    .bytes_available_i (avail_q),
    .current_pc_i      (pc_q),
    .rec_o             (dec_rec)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      out_q <= dec_rec;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, out_q.val, out_q.rb, out_q.ra, out_q.rd, out_q.suf,
                            out_q.test, out_q.cond, out_q.form, out_q.mn, out_q.used};

`ifndef ASSERT_OFF
  a_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> in_vld_q)
    else $error("accepted item not held in input register");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_out |=> out_vld_q)
    else $error("decoded item not held in result register");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while both stages are full and stalled");

  a_undecoded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.used != USED_LONG) |-> (out_q.mn == 7'd0 && out_q.form == F_NONE))
    else $error("short or truncated item carries a decode");

  a_invalid_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.mn == 7'd0) |-> (out_q.val == 32'd0 && out_q.rd == 5'd0))
    else $error("invalid item carries operands");
`endif

endmodule

// ----- sim/risc_instruction_field_decoder_core_test.sv -----
module risc_instruction_field_decoder_core_test
  import rifd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transaction before the run is declared hung
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned RandomItems = 1200;
  // Receiver hold-off window, in receiver cycles
  localparam int unsigned HoldStart = 600;
  localparam int unsigned HoldEnd   = 1000;

  // One decode record as seen on the result stream
  typedef struct {
    logic [2:0]  consumed;
    logic [6:0]  mnemonic;
    op_form_e    form;
    logic [3:0]  cond;
    logic [1:0]  test;
    logic        suffix;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [31:0] value;
  } field_rec_t;

  // One instruction offered on the input stream
  typedef struct {
    logic [15:0] fh;
    logic [15:0] sh;
    logic [2:0]  avail;
    logic [31:0] pc;
    bit          typed;  // expectation given by hand instead of predicted
    field_rec_t  exp;
  } stim_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_e;

  // Mnemonic for each minor opcode of major 0
  localparam logic [6:0] minor_mnemonic_lut [64] = '{
    7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,
    7'd9,  7'd10, 7'd11, 7'd0,  7'd12, 7'd13, 7'd0,  7'd14,
    7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22,
    7'd23, 7'd0,  7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
    7'd30, 7'd31, 7'd32, 7'd33, 7'd0,  7'd0,  7'd0,  7'd0,
    7'd40, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47,
    7'd48, 7'd49, 7'd0,  7'd50, 7'd51, 7'd52, 7'd0,  7'd53,
    7'd54, 7'd0,  7'd55, 7'd56, 7'd57, 7'd58, 7'd59, 7'd60
  };

  // Immediate sub-opcode: defined codes and mnemonic offsets
  localparam bit [7:0]   imm_sub_valid = 8'b0111_0101;
  localparam logic [2:0] imm_sub_ofs [8] = '{
    3'd0, 3'd0, 3'd1, 3'd0, 3'd2, 3'd3, 3'd4, 3'd0
  };

  // Decoded major opcodes other than the minor group
  localparam logic [4:0] long_majors [9] = '{
    MAJ_IMM, MAJ_JUMP, MAJ_LDST_PRE, MAJ_BRANCH, MAJ_IMM_SH,
    MAJ_LDST_POST, MAJ_RI, MAJ_RI_C, MAJ_RI_D
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;

  stim_t      instr_stream [$];
  field_rec_t pending_decodes [$];
  stim_t      cur_item;
  int         n_errors = 0;
  int         idle_cycles = 0;

  risc_instruction_field_decoder_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Record of an item that decodes to nothing
  function automatic field_rec_t blank_rec(logic [2:0] used);
    field_rec_t r;
    r.consumed = used;
    r.mnemonic = '0;
    r.form     = F_NONE;
    r.cond     = COND_ALWAYS;
    r.test     = TEST_NONE;
    r.suffix   = 1'b0;
    r.rd       = '0;
    r.ra       = '0;
    r.rb       = '0;
    r.value    = '0;
    return r;
  endfunction

  function automatic field_rec_t set_operands(field_rec_t r, logic [6:0] mn, op_form_e f,
                                              logic [4:0] d, logic [4:0] a, logic [4:0] b,
                                              logic [31:0] v);
    r.mnemonic = mn;
    r.form     = f;
    r.rd       = d;
    r.ra       = a;
    r.rb       = b;
    r.value    = v;
    return r;
  endfunction

  // Expected decode record for one instruction
  function automatic field_rec_t decode_fields(logic [15:0] fh, logic [15:0] sh,
                                               logic [2:0] avail, logic [31:0] pc);
    field_rec_t  r;
    logic [29:0] w;
    logic [4:0]  major, rd_f, ra_f, rb_f;
    logic [5:0]  minor;
    logic [6:0]  mn, cel_base;
    logic        cu;
    logic [2:0]  sub;
    logic [15:0] imm16;
    logic [19:0] disp;
    r = blank_rec(USED_NONE);
    if (avail < 3'd2) return r;
    if (!fh[15]) begin
      r.consumed = USED_SHORT;
      return r;
    end
    if (avail < 3'd4) return r;
    r.consumed = USED_LONG;

    w     = {sh[14:0], fh[14:0]};
    major = w[29:25];
    rd_f  = w[24:20];
    ra_f  = w[19:15];
    rb_f  = w[14:10];
    minor = w[6:1];
    cu    = w[0];
    mn    = minor_mnemonic_lut[minor];

    case (major)
      MAJ_MINOR: begin
        case (minor)
          6'h00, 6'h05: r = set_operands(r, mn, F_NONE, '0, '0, '0, '0);
          6'h01: r = set_operands(r, mn, F_D, '0, '0, '0, 32'(w[24:10]));
          6'h02: begin
            r = set_operands(r, mn, F_D, '0, '0, '0, 32'(ra_f));
            r.cond = rb_f[3:0];
          end
          6'h03: r = set_operands(r, mn, F_D, '0, '0, '0, 32'(ra_f));
          6'h04: begin
            r = set_operands(r, mn, F_R, ra_f, '0, '0, '0);
            r.cond   = rb_f[3:0];
            r.suffix = cu;
          end
          6'h06, 6'h07: r = set_operands(r, mn, F_RM, rd_f, ra_f, '0, '0);
          6'h08, 6'h09, 6'h0A, 6'h10, 6'h11, 6'h12, 6'h13,
          6'h18, 6'h1A, 6'h1B, 6'h1C, 6'h1D, 6'h1E, 6'h1F: begin
            r = set_operands(r, mn, F_RRR, rd_f, ra_f, rb_f, '0);
            r.suffix = cu;
          end
          // compares: test mode rides in the low bits of rD
          6'h0C, 6'h0D: begin
            r = set_operands(r, mn, F_RR, ra_f, rb_f, '0, '0);
            r.test   = rd_f[1:0];
            r.suffix = cu;
          end
          6'h0F, 6'h2C, 6'h2D, 6'h2E, 6'h2F: begin
            r = set_operands(r, mn, F_RR, rd_f, ra_f, '0, '0);
            r.suffix = cu;
          end
          6'h14, 6'h15, 6'h16, 6'h17,
          6'h38, 6'h3A, 6'h3B, 6'h3C, 6'h3D, 6'h3E, 6'h3F: begin
            r = set_operands(r, mn, F_RRD, rd_f, ra_f, rb_f, '0);
            r.suffix = cu;
          end
          6'h20: begin
            r = set_operands(r, mn, F_RR, ra_f, rb_f, '0, '0);
            r.suffix = cu;
          end
          6'h21, 6'h22, 6'h23: r = set_operands(r, mn, F_RR, ra_f, rb_f, '0, '0);
          // coprocessor moves: rB selects the variant
          6'h24, 6'h25: begin
            cel_base = (minor == 6'h24) ? MN_MFCEL : MN_MTCEL;
            if (rb_f == CEL_LO || rb_f == CEL_HI)
              r = set_operands(r, 7'(cel_base + rb_f - 1), F_R, rd_f, '0, '0, '0);
            else if (rb_f == CEL_BOTH)
              r = set_operands(r, 7'(cel_base + 2), F_RR, rd_f, ra_f, '0, '0);
          end
          6'h28, 6'h29: r = set_operands(r, mn, F_RPR, ra_f, rb_f, '0, '0);
          6'h2A: begin
            r = set_operands(r, mn, F_NONE, '0, '0, '0, '0);
            r.cond = rb_f[3:0];
          end
          6'h2B: begin
            r = set_operands(r, mn, F_RR, rd_f, ra_f, '0, '0);
            r.cond = rb_f[3:0];
          end
          6'h30, 6'h37: r = set_operands(r, mn, F_MP, '0, ra_f, '0, '0);
          6'h31, 6'h33, 6'h34, 6'h35: r = set_operands(r, mn, F_RMP, rd_f, ra_f, '0, '0);
          default: ;
        endcase
      end
      MAJ_IMM, MAJ_IMM_SH: begin
        sub   = w[19:17];
        imm16 = w[16:1];
        if (imm_sub_valid[sub]) begin
          mn = 7'(((major == MAJ_IMM) ? MN_ADDI : MN_ADDIS) + imm_sub_ofs[sub]);
          if (imm_sub_ofs[sub] < 3'd2)
            r = set_operands(r, mn, F_RD, rd_f, '0, '0, {{16{imm16[15]}}, imm16});
          else
            r = set_operands(r, mn, F_RH, rd_f, '0, '0, {16'd0, imm16});
          r.suffix = cu;
        end
      end
      MAJ_JUMP: begin
        r = set_operands(r, MN_J, F_W, '0, '0, '0,
                         (pc & 32'hFC00_0000) | {7'd0, w[24:1], 1'b0});
        r.suffix = cu;
      end
      MAJ_LDST_PRE, MAJ_LDST_POST: begin
        r = set_operands(r, 7'(MN_LW + w[2:0]),
                         (major == MAJ_LDST_PRE) ? F_RMDP : F_RMPD,
                         rd_f, ra_f, '0, {{20{w[14]}}, w[14:3]});
      end
      MAJ_BRANCH: begin
        disp = {w[24:15], w[9:1], 1'b0};
        r = set_operands(r, MN_B, F_W, '0, '0, '0, pc + {{12{disp[19]}}, disp});
        r.cond   = w[13:10];
        r.suffix = cu;
      end
      MAJ_RI, MAJ_RI_C, MAJ_RI_D: begin
        mn = (major == MAJ_RI) ? MN_ADDRI :
             (major == MAJ_RI_C) ? 7'(MN_ADDRI + 1) : 7'(MN_ADDRI + 2);
        r = set_operands(r, mn, F_RRH, ra_f, rd_f, '0, {{18{w[14]}}, w[14:1]});
        r.suffix = cu;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic field_rec_t unpack_result(logic [71:0] d);
    field_rec_t r;
    r.consumed = d[2:0];
    r.mnemonic = d[9:3];
    r.form     = op_form_e'(d[13:10]);
    r.cond     = d[17:14];
    r.test     = d[19:18];
    r.suffix   = d[20];
    r.rd       = d[25:21];
    r.ra       = d[30:26];
    r.rb       = d[35:31];
    r.value    = d[67:36];
    return r;
  endfunction

  // Long instruction word split into the two halfwords {second, first}
  function automatic logic [31:0] halves_of(logic [29:0] w);
    return {1'b1, w[29:15], 1'b1, w[14:0]};
  endfunction

  function automatic logic [29:0] minor_word(logic [5:0] minor, logic [4:0] d, logic [4:0] a,
                                             logic [4:0] b, logic cu);
    return {MAJ_MINOR, d, a, b, 3'b111, minor, cu};
  endfunction

  task automatic add_row(logic [31:0] halves, logic [2:0] avail, logic [31:0] pc,
                         bit typed, field_rec_t exp);
    stim_t it;
    it.sh    = halves[31:16];
    it.fh    = halves[15:0];
    it.avail = avail;
    it.pc    = pc;
    it.typed = typed;
    it.exp   = exp;
    instr_stream.push_back(it);
  endtask

  task automatic add_pred(logic [29:0] w, logic [31:0] pc);
    add_row(halves_of(w), 3'd4, pc, 1'b0, blank_rec(USED_NONE));
  endtask

  // Mostly well-formed long instructions; some raw noise of any length
  function automatic stim_t make_random_item();
    stim_t       it;
    logic [29:0] w;
    logic [4:0]  major;
    int          pick;
    it.typed = 1'b0;
    it.exp   = blank_rec(USED_NONE);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it.fh    = 16'($urandom);
      it.sh    = 16'($urandom);
      it.avail = 3'($urandom_range(0, 4));
    end else begin
      if (pick < 45) major = MAJ_MINOR;
      else if (pick < 88) major = long_majors[$urandom_range(0, 8)];
      else major = 5'($urandom);
      w = {major, 25'($urandom)};
      // steer coprocessor moves onto their valid selectors half the time
      if (major == MAJ_MINOR && (w[6:1] == 6'h24 || w[6:1] == 6'h25) && $urandom_range(0, 1))
        w[14:10] = 5'($urandom_range(0, 3));
      it.fh    = {1'b1, w[14:0]};
      it.sh    = {1'($urandom), w[29:15]};
      it.avail = 3'd4;
    end
    case ($urandom_range(0, 9))
      0:       it.pc = 32'h0000_0000;
      1:       it.pc = 32'hFFFF_FFFF;
      2:       it.pc = 32'hFFFF_FFFF - $urandom_range(0, 32'h7FFFF);
      default: it.pc = $urandom;
    endcase
    return it;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  // Scoreboard: predict on each input transaction, compare each output one
  always @(posedge clk_i) begin
    field_rec_t want, got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = unpack_result(m_axis_tdata_o);
        if (pending_decodes.size() == 0) begin
          $error("result transaction with no pending decode");
          n_errors++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("consumed_bytes", 32'(want.consumed), 32'(got.consumed));
          check_field("mnemonic", 32'(want.mnemonic), 32'(got.mnemonic));
          check_field("operand_form", 32'(want.form), 32'(got.form));
          check_field("cond_code", 32'(want.cond), 32'(got.cond));
          check_field("test_mode", 32'(want.test), 32'(got.test));
          check_field("suffix_flag", 32'(want.suffix), 32'(got.suffix));
          check_field("reg_d", 32'(want.rd), 32'(got.rd));
          check_field("reg_a", 32'(want.ra), 32'(got.ra));
          check_field("reg_b", 32'(want.rb), 32'(got.rb));
          check_field("operand_value", want.value, got.value);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (cur_item.typed)
          pending_decodes.push_back(cur_item.exp);
        else
          pending_decodes.push_back(decode_fields(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16],
                                                  s_axis_tdata_i[34:32], s_axis_tdata_i[66:35]));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL risc_instruction_field_decoder_core");
      $finish;
    end
  end

  // Receiver: changing stall patterns, one long hold-off to back up the block
  initial begin
    int       rx_cycle;
    rx_mode_e rx_mode;
    rx_cycle = 0;
    rx_mode  = RX_OPEN;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle >= HoldStart && rx_cycle < HoldEnd) begin
        m_axis_tready_i = 1'b0;
      end else begin
        if (rx_cycle % 50 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
        case (rx_mode)
          RX_OPEN:   m_axis_tready_i = 1'b1;
          RX_COIN:   m_axis_tready_i = 1'($urandom_range(0, 1));
          RX_COMB:   m_axis_tready_i = (rx_cycle[1:0] != 2'b11);
          RX_SPARSE: m_axis_tready_i = ($urandom_range(0, 3) == 0);
          default:   m_axis_tready_i = 1'b1;
        endcase
      end
    end
  end

  // Stimulus, sender and end of run
  initial begin
    int burst_left;
    int gap;

    // too short, short and undecoded items, expected records typed in
    add_row(32'hFFFF_FFFF, 3'd0, 32'h0000_0000, 1'b1, blank_rec(USED_NONE));
    add_row(32'h0000_0000, 3'd1, 32'hFFFF_FFFF, 1'b1, blank_rec(USED_NONE));
    add_row(32'hFFFF_7FFF, 3'd2, 32'hFFFF_FFFF, 1'b1, blank_rec(USED_SHORT));
    add_row(32'h0000_8000, 3'd3, 32'h0000_0000, 1'b1, blank_rec(USED_NONE));
    add_row(32'hFFFF_0000, 3'd4, 32'h1234_5678, 1'b1, blank_rec(USED_SHORT));
    add_row(32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF, 1'b1, blank_rec(USED_LONG));
    add_row(halves_of({5'h06, 25'h1FF_FFFF}), 3'd4, 32'h0, 1'b1, blank_rec(USED_LONG));
    add_row(halves_of(minor_word(6'h0B, 5'd31, 5'd31, 5'd31, 1'b1)), 3'd4, 32'h0, 1'b1,
            blank_rec(USED_LONG));
    add_row(halves_of({MAJ_IMM, 5'd31, 3'd1, 16'hFFFF, 1'b1}), 3'd4, 32'h0, 1'b1,
            blank_rec(USED_LONG));
    // decoded forms, checked against the predictor
    add_pred(minor_word(6'h00, 5'd0, 5'd0, 5'd0, 1'b0), 32'h0);
    add_pred(minor_word(6'h01, 5'd31, 5'd31, 5'd31, 1'b1), 32'hFFFF_FFFF);
    add_pred(minor_word(6'h02, 5'd5, 5'd31, 5'd31, 1'b0), 32'h0);
    add_pred(minor_word(6'h04, 5'd0, 5'd17, 5'd14, 1'b1), 32'h0);
    add_pred(minor_word(6'h0C, 5'd2, 5'd3, 5'd4, 1'b1), 32'h0);
    add_pred(minor_word(6'h0D, 5'd31, 5'd1, 5'd2, 1'b0), 32'h0);
    add_pred(minor_word(6'h24, 5'd7, 5'd8, CEL_LO, 1'b0), 32'h0);
    add_pred(minor_word(6'h24, 5'd7, 5'd8, CEL_HI, 1'b0), 32'h0);
    add_pred(minor_word(6'h25, 5'd9, 5'd10, CEL_BOTH, 1'b0), 32'h0);
    add_pred(minor_word(6'h25, 5'd9, 5'd10, 5'd0, 1'b1), 32'h0);
    add_pred({MAJ_IMM, 5'd1, 3'd0, 16'h8000, 1'b1}, 32'h0);
    add_pred({MAJ_IMM_SH, 5'd31, 3'd6, 16'hFFFF, 1'b0}, 32'h0);
    add_pred({MAJ_JUMP, 24'hFF_FFFF, 1'b1}, 32'hFFFF_FFFF);
    add_pred({MAJ_LDST_PRE, 5'd31, 5'd0, 12'h800, 3'd7}, 32'h0);
    add_pred({MAJ_LDST_POST, 5'd0, 5'd31, 12'h7FF, 3'd0}, 32'h0);
    // branches wrapping below zero and past the top
    add_pred({MAJ_BRANCH, 10'h200, 5'd15, 9'h000, 1'b1}, 32'h0000_0000);
    add_pred({MAJ_BRANCH, 10'h1FF, 5'd3, 9'h1FF, 1'b0}, 32'hFFFF_FFF0);
    add_pred({MAJ_RI_D, 5'd31, 5'd0, 14'h2000, 1'b1}, 32'h0);
    repeat (RandomItems) instr_stream.push_back(make_random_item());

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sender: bursts of back-to-back transactions with random gaps
    burst_left = 0;
    foreach (instr_stream[i]) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          s_axis_tvalid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 40);
      end
      cur_item        = instr_stream[i];
      s_axis_tdata_i  = {5'd0, cur_item.pc, cur_item.avail, cur_item.sh, cur_item.fh};
      s_axis_tvalid_i = 1'b1;
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
      @(negedge clk_i);
      burst_left--;
    end
    s_axis_tvalid_i = 1'b0;

    // drain, then allow for the pipeline depth
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_errors == 0)
      $display("PASS risc_instruction_field_decoder_core");
    else
      $display("FAIL risc_instruction_field_decoder_core");
    $finish;
  end

endmodule

// ----- risc_instruction_field_decoder_core.f -----
design/rifd_pkg.sv
design/rifd_minor_dec.sv
design/rifd_major_dec.sv
design/risc_instruction_field_decoder_core.sv
sim/risc_instruction_field_decoder_core_test.sv
